// File: rtl/hcb_pkg.sv
// Package with the payload types, register indexes and mod-26 helpers of the Hill cipher block.
`default_nettype none
package hcb_pkg;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned MOD = 26;
  localparam int unsigned MAX_BLOCK = 4;

  localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_ROW0 = 3'd1;
  localparam logic [2:0] REG_KEY_ROW1 = 3'd2;
  localparam logic [2:0] REG_KEY_ROW2 = 3'd3;
  localparam logic [2:0] REG_KEY_ROW3 = 3'd4;

  typedef struct packed {
    logic [4:0] letter3;
    logic [4:0] letter2;
    logic [4:0] letter1;
    logic [4:0] letter0;
    logic       action;
  } hcb_in_t;

  typedef struct packed {
    logic       status;
    logic [4:0] out3;
    logic [4:0] out2;
    logic [4:0] out1;
    logic [4:0] out0;
  } hcb_out_t;

  // Reduces a value below 52 modulo 26.
  function automatic logic [4:0] mod26_5(input logic [5:0] v);
    mod26_5 = (v >= 6'd26) ? 5'(v - 6'd26) : v[4:0];
  endfunction

  // Reduces a value below 1024 modulo 26.
  function automatic logic [4:0] mod26_10(input logic [9:0] v);
    logic [25:0] q;
    logic [9:0]  rem;
    begin
      q = {16'd0, v} * 26'd40330;
      rem = v - {4'd0, q[25:20]} * 10'd26;
      mod26_10 = (rem >= 10'd26) ? 5'(rem - 10'd26) : rem[4:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/hill_cipher_block.sv
// Top level of the Hill cipher block: key registers, sequencer and shared multiply-mod unit.
//
// Usage: write block_size (index 0) and key rows (indexes 1..4) on the cfg_ channel
// while idle; cfg_ready is always high. Send one item on in_ per block: action 0
// encrypts, 1 decrypts. One result item appears on out_ per input item.
// Every product goes through one 5x5-bit multiply and mod-26 unit, one product a
// cycle. Encrypt steps through the n*n products of the block, then raises out_valid.
// Decrypt steps all 24 permutations of four for the determinant, searches the
// determinant inverse, steps all 24 permutations again for each of the n*n minors,
// then scales the adjugate, multiplies it with the block and presents the result;
// when the key is not invertible it presents a status result after the search.
// in_ready is high only when no item is in work and the output register is empty
// or being taken in the same cycle, so the next item can be accepted at the edge
// that takes the result. A stalled receiver holds the result in the output
// register and blocks new items. Synchronous reset sets block_size to 2, clears
// the key, returns the sequencer to idle and empties the output register.
`default_nettype none
module hill_cipher_block import hcb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire hcb_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output hcb_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DET  = 7'b0000010,
    S_INV  = 7'b0000100,
    S_COF  = 7'b0001000,
    S_SCL  = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  bsize_r;
  logic [19:0] key_r [4];
  logic [4:0]  k_r [4][4];
  logic [4:0]  m_r [4][4];
  logic [4:0]  blk_r [4];
  logic [4:0]  res_r [4];
  logic [1:0]  n_r;
  logic [4:0]  acc_r, term_r, dinv_r, det_r;
  logic [4:0]  perm_r;
  logic [1:0]  pos_r, row_r, col_r;
  logic [1:0]  ci_r, cj_r;
  logic [4:0]  x_r;
  hcb_out_t    out_r;
  logic        ov_r;

  // Permutation tables over 4 elements, lexicographic, with parity.
  function automatic logic [1:0] perm_at(input logic [4:0] p, input logic [1:0] i);
    logic [7:0] w;
    begin
      case (p)
        5'd0:  w = 8'b00_01_10_11;
        5'd1:  w = 8'b00_01_11_10;
        5'd2:  w = 8'b00_10_01_11;
        5'd3:  w = 8'b00_10_11_01;
        5'd4:  w = 8'b00_11_01_10;
        5'd5:  w = 8'b00_11_10_01;
        5'd6:  w = 8'b01_00_10_11;
        5'd7:  w = 8'b01_00_11_10;
        5'd8:  w = 8'b01_10_00_11;
        5'd9:  w = 8'b01_10_11_00;
        5'd10: w = 8'b01_11_00_10;
        5'd11: w = 8'b01_11_10_00;
        5'd12: w = 8'b10_00_01_11;
        5'd13: w = 8'b10_00_11_01;
        5'd14: w = 8'b10_01_00_11;
        5'd15: w = 8'b10_01_11_00;
        5'd16: w = 8'b10_11_00_01;
        5'd17: w = 8'b10_11_01_00;
        5'd18: w = 8'b11_00_01_10;
        5'd19: w = 8'b11_00_10_01;
        5'd20: w = 8'b11_01_00_10;
        5'd21: w = 8'b11_01_10_00;
        5'd22: w = 8'b11_10_00_01;
        5'd23: w = 8'b11_10_01_00;
        default: w = 8'b00_01_10_11;
      endcase
      case (i)
        2'd0: perm_at = w[7:6];
        2'd1: perm_at = w[5:4];
        2'd2: perm_at = w[3:2];
        default: perm_at = w[1:0];
      endcase
    end
  endfunction

  function automatic logic perm_odd(input logic [4:0] p);
    logic [1:0] v [4];
    logic o;
    begin
      o = 1'b0;
      for (int a = 0; a < 4; a++) v[a] = perm_at(p, a[1:0]);
      for (int a = 0; a < 4; a++)
        for (int b = a + 1; b < 4; b++)
          if (v[a] > v[b]) o = ~o;
      perm_odd = o;
    end
  endfunction

  // Size of a permutation prefix: order k uses first k! permutations of {0..k-1}
  // when the last 4-k elements stay fixed; lexicographic order puts them first
  // only for k=1 and k=4, so permutations are enumerated at full size and filtered.
  logic [2:0] dim;
  logic [4:0] nfact;
  logic [1:0] pi;
  logic [1:0] mr, mc;
  logic       keep;
  logic [4:0] ma, mb;
  logic [9:0] prod;
  logic [4:0] pm;

  always_comb begin
    dim = (state_r == S_DET) ? {1'b0, n_r} + 3'd1 : {1'b0, n_r};
    nfact = 5'd23;
    keep = 1'b1;
    for (int a = 0; a < 4; a++)
      if (a >= dim && perm_at(perm_r, a[1:0]) != a[1:0]) keep = 1'b0;
    pi = perm_at(perm_r, pos_r);
    mr = pos_r;
    mc = pi;
    if (state_r == S_COF) begin
      mr = (pos_r >= cj_r) ? pos_r + 2'd1 : pos_r;
      mc = (pi >= ci_r) ? pi + 2'd1 : pi;
    end
    ma = 5'd0;
    mb = 5'd0;
    case (state_r)
      S_DET, S_COF: begin
        ma = (pos_r == 2'd0) ? 5'd1 : term_r;
        mb = k_r[mr][mc];
      end
      S_INV: begin ma = det_r; mb = x_r; end
      S_SCL: begin ma = m_r[row_r][col_r]; mb = dinv_r; end
      S_MUL: begin ma = m_r[row_r][col_r]; mb = blk_r[col_r]; end
      default: begin ma = 5'd0; mb = 5'd0; end
    endcase
    prod = {5'd0, ma} * {5'd0, mb};
    pm = mod26_10(prod);
  end

  wire logic last_pos = (state_r == S_DET) ? (pos_r == n_r) : (pos_r == n_r - 2'd1);
  wire logic [4:0] sacc = perm_odd(perm_r) ^ ((state_r == S_COF) && (ci_r[0] ^ cj_r[0]))
                          ? mod26_5({1'b0, acc_r} + 6'd26 - {1'b0, pm})
                          : mod26_5({1'b0, acc_r} + {1'b0, pm});
  wire logic [4:0] madd = mod26_5({1'b0, acc_r} + {1'b0, pm});

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = in_data.action ? S_DET : S_MUL;
      S_DET: if (perm_r == nfact && (last_pos || !keep)) state_nxt = S_INV;
      S_INV: if (pm == 5'd1 || x_r == 5'd25) state_nxt = (pm == 5'd1) ? S_COF : S_DONE;
      S_COF: if (perm_r == nfact && (last_pos || !keep) && ci_r == n_r && cj_r == n_r)
               state_nxt = S_SCL;
      S_SCL: if (row_r == n_r && col_r == n_r) state_nxt = S_MUL;
      S_MUL: if (row_r == n_r && col_r == n_r) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bsize_r <= 3'd2;
      for (int a = 0; a < 4; a++) key_r[a] <= 20'd0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_BLOCK_SIZE) bsize_r <= cfg_data[2:0];
        else if (cfg_index inside {[REG_KEY_ROW0:REG_KEY_ROW3]})
          key_r[2'(cfg_index - REG_KEY_ROW0)] <= cfg_data;
      end
      if (state_r == S_DONE) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
    end
  end

  wire logic [1:0] nl = (bsize_r < 3'd2) ? 2'd1 :
                        (bsize_r > 3'(MAX_BLOCK)) ? 2'(MAX_BLOCK - 1) : 2'(bsize_r - 3'd1);

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r <= nl;
        perm_r <= 5'd0; pos_r <= 2'd0; acc_r <= 5'd0; term_r <= 5'd1;
        row_r <= 2'd0; col_r <= 2'd0; ci_r <= 2'd0; cj_r <= 2'd0; x_r <= 5'd1;
        for (int r = 0; r < 4; r++) begin
          blk_r[r] <= (r <= nl) ? mod26_5({1'b0, in_data[1 + 5*r +: 5]}) : 5'd0;
          res_r[r] <= 5'd0;
          for (int c = 0; c < 4; c++) begin
            k_r[r][c] <= (r <= nl && c <= nl) ? mod26_5({1'b0, key_r[r][5*c +: 5]}) : 5'd0;
            m_r[r][c] <= (r <= nl && c <= nl) ? mod26_5({1'b0, key_r[r][5*c +: 5]}) : 5'd0;
          end
        end
      end
      S_DET, S_COF: begin
        if (!keep || last_pos) begin
          if (keep) acc_r <= sacc;
          pos_r <= 2'd0;
          term_r <= 5'd1;
          perm_r <= (perm_r == nfact) ? 5'd0 : perm_r + 5'd1;
          if (perm_r == nfact) begin
            if (state_r == S_DET) begin
              det_r <= keep ? sacc : acc_r;
              acc_r <= 5'd0;
            end else begin
              m_r[ci_r][cj_r] <= (n_r == 2'd0) ? 5'd1 : (keep ? sacc : acc_r);
              acc_r <= 5'd0;
              cj_r <= (cj_r == n_r) ? 2'd0 : cj_r + 2'd1;
              if (cj_r == n_r) ci_r <= ci_r + 2'd1;
            end
          end
        end else begin
          term_r <= pm;
          pos_r <= pos_r + 2'd1;
        end
      end
      S_INV: begin
        x_r <= x_r + 5'd1;
        if (pm == 5'd1) dinv_r <= x_r;
        else if (x_r == 5'd25) out_r <= '{status: 1'b1, default: '0};
      end
      S_SCL, S_MUL: begin
        if (state_r == S_SCL) m_r[row_r][col_r] <= pm;
        else begin
          acc_r <= (col_r == n_r) ? 5'd0 : madd;
          if (col_r == n_r) res_r[row_r] <= madd;
        end
        col_r <= (col_r == n_r) ? 2'd0 : col_r + 2'd1;
        if (col_r == n_r) row_r <= (row_r == n_r) ? 2'd0 : row_r + 2'd1;
        if (state_r == S_MUL && row_r == n_r && col_r == n_r)
          out_r <= '{status: 1'b0,
                     out3: (n_r == 2'd3) ? madd : res_r[3],
                     out2: (n_r == 2'd2) ? madd : res_r[2],
                     out1: (n_r == 2'd1) ? madd : res_r[1],
                     out0: res_r[0]};
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("item accepted while busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result not presented");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.out0 == 5'd0 && out_data.out1 == 5'd0))
    else $error("nonzero letters with bad key");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");
`endif
endmodule
`default_nettype wire

// File: verif/tb_hill_cipher_block.sv
// Testbench for the Hill cipher block: mod-26 predictor, queued driver and checking monitor.
module tb_hill_cipher_block;
  import hcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int NUM_RANDOM = 1640;
  localparam int HOLD_LEN = 3000;
  localparam logic ACT_ENC = 1'b0;
  localparam logic ACT_DEC = 1'b1;
  localparam logic [2:0] REG_UNKNOWN = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hcb_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hcb_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  hcb_in_t pending_blocks[$];
  hcb_out_t expected_letters[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int phase_no = -1;
  int hold_cnt = 0;
  logic hold_active = 1'b0;
  logic hold_done = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  logic [2:0] cur_size = 3'd2;
  logic [19:0] cur_key[4] = '{default: '0};

  hill_cipher_block dut (.*);

  always #2 clk = ~clk;

  function automatic int det_of(int m[4][4], int k);
    int sub[4][4];
    int acc, dr, dc;
    if (k == 1) return m[0][0] % 26;
    acc = 0;
    for (int i = 0; i < k; i++) begin
      sub = '{default: 0};
      dr = 0;
      for (int r = 1; r < k; r++) begin
        dc = 0;
        for (int c = 0; c < k; c++) begin
          if (c != i) begin
            sub[dr][dc] = m[r][c];
            dc++;
          end
        end
        dr++;
      end
      if (i % 2 == 0) acc = (acc + m[0][i] * det_of(sub, k - 1)) % 26;
      else acc = (acc + 26 * 26 - m[0][i] * det_of(sub, k - 1) % 26) % 26;
    end
    return acc;
  endfunction

  function automatic hcb_out_t cipher_block(hcb_in_t item);
    int key[4][4];
    int mat[4][4];
    int sub[4][4];
    int blk[4];
    int res[4];
    int n, d, dinv, dr, dc, cof, acc;
    hcb_out_t o;
    n = (cur_size < 2) ? 2 : (cur_size > 4) ? 4 : int'(cur_size);
    key = '{default: 0};
    mat = '{default: 0};
    blk = '{default: 0};
    res = '{default: 0};
    for (int r = 0; r < n; r++) begin
      blk[r] = int'(item[1 + 5 * r +: 5]) % 26;
      for (int c = 0; c < n; c++) key[r][c] = int'(cur_key[r][5 * c +: 5]) % 26;
    end
    o = '0;
    if (item.action == ACT_ENC) begin
      mat = key;
    end else begin
      d = det_of(key, n);
      dinv = 0;
      for (int x = 25; x >= 1; x--) if ((d * x) % 26 == 1) dinv = x;
      if (dinv == 0) begin
        o.status = 1'b1;
        return o;
      end
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          sub = '{default: 0};
          dr = 0;
          for (int rr = 0; rr < n; rr++) begin
            if (rr != r) begin
              dc = 0;
              for (int cc = 0; cc < n; cc++) begin
                if (cc != c) begin
                  sub[dr][dc] = key[rr][cc];
                  dc++;
                end
              end
              dr++;
            end
          end
          cof = det_of(sub, n - 1);
          if ((r + c) % 2 != 0) cof = (26 - cof) % 26;
          mat[c][r] = (cof * dinv) % 26;
        end
      end
    end
    for (int r = 0; r < n; r++) begin
      acc = 0;
      for (int c = 0; c < n; c++) acc += mat[r][c] * blk[c];
      res[r] = acc % 26;
    end
    o.out0 = 5'(res[0]);
    o.out1 = 5'(res[1]);
    o.out2 = 5'(res[2]);
    o.out3 = 5'(res[3]);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_letters.push_back(cipher_block(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_blocks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (phase_no == 4 && !hold_done) begin
      if (hold_cnt < HOLD_LEN) begin
        hold_active <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end else begin
        hold_active <= 1'b0;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    hcb_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_letters.size() == 0) begin
          report_mismatch("unexpected result", int'(out_data), 0);
        end else begin
          want = expected_letters.pop_front();
          if (out_data.out0 !== want.out0) report_mismatch("out0", out_data.out0, want.out0);
          if (out_data.out1 !== want.out1) report_mismatch("out1", out_data.out1, want.out1);
          if (out_data.out2 !== want.out2) report_mismatch("out2", out_data.out2, want.out2);
          if (out_data.out3 !== want.out3) report_mismatch("out3", out_data.out3, want.out3);
          if (out_data.status !== want.status) begin
            report_mismatch("status", out_data.status, want.status);
          end
        end
      end
      if (hold_active) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BLOCK_SIZE) cur_size = value[2:0];
    else if (idx inside {[REG_KEY_ROW0:REG_KEY_ROW3]}) cur_key[idx - REG_KEY_ROW0] = value;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || in_valid || expected_letters.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_row();
    logic [19:0] row;
    for (int c = 0; c < 4; c++) begin
      row[5 * c +: 5] = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
    end
    return row;
  endfunction

  function automatic hcb_in_t rand_block();
    hcb_in_t b;
    b.action = 1'($urandom_range(1));
    b.letter0 = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
    b.letter1 = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
    b.letter2 = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
    b.letter3 = ($urandom_range(15) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
    return b;
  endfunction

  task automatic load_key(logic [2:0] size, logic [19:0] r0, logic [19:0] r1,
                          logic [19:0] r2, logic [19:0] r3);
    write_reg(REG_BLOCK_SIZE, size);
    write_reg(REG_KEY_ROW0, r0);
    write_reg(REG_KEY_ROW1, r1);
    write_reg(REG_KEY_ROW2, r2);
    write_reg(REG_KEY_ROW3, r3);
  endtask

  initial begin
    logic [2:0] sizes[8] = '{3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd5, 3'd7, 3'd6};
    hcb_in_t b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key is all zero: decrypt is not invertible, encrypt gives zeros.
    pending_blocks.push_back('{5'd25, 5'd25, 5'd25, 5'd25, ACT_ENC});
    pending_blocks.push_back('{5'd3, 5'd2, 5'd1, 5'd0, ACT_DEC});
    wait_drained();
    // Classic order two key 3 3 / 2 5, plus an unused index write.
    load_key(3'd2, 20'h00063, 20'h000A2, 20'hFFFFF, 20'hFFFFF);
    write_reg(REG_UNKNOWN, 20'h12345);
    pending_blocks.push_back('{5'd0, 5'd0, 5'd7, 5'd7, ACT_ENC});
    pending_blocks.push_back('{5'd31, 5'd31, 5'd25, 5'd0, ACT_DEC});
    pending_blocks.push_back('{5'd0, 5'd0, 5'd26, 5'd31, ACT_ENC});
    wait_drained();
    // Identity at order four with an out of range entry, then an invertible order two key set with block size 0.
    load_key(3'd7, 20'h00001, 20'h00020, 20'h00400, 20'hF8000 | 20'h08000);
    pending_blocks.push_back('{5'd25, 5'd0, 5'd13, 5'd1, ACT_DEC});
    pending_blocks.push_back('{5'd31, 5'd30, 5'd26, 5'd27, ACT_ENC});
    wait_drained();
    load_key(3'd0, 20'h00022, 20'h00021, 20'h0, 20'h0);
    pending_blocks.push_back('{5'd4, 5'd3, 5'd2, 5'd1, ACT_DEC});
    pending_blocks.push_back('{5'd4, 5'd3, 5'd2, 5'd1, ACT_ENC});
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 70; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 70; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      phase_no = phase;
      load_key(sizes[phase], rand_row(), rand_row(), rand_row(), rand_row());
      for (int i = 0; i < NUM_RANDOM / 8; i++) begin
        b = rand_block();
        pending_blocks.push_back(b);
      end
      wait_drained();
    end

    if (error_count == 0 && expected_letters.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
